@@ rtl/core/tkpbh_pkg.sv @@
// ============================================================================
// Top-K points by height: shared definitions
// Sizes of the kept list and coordinate format, and the point record type.
// ============================================================================
package tkpbh_pkg;

	localparam int KEEP_COUNT  = 8;
	localparam int COORD_WIDTH = 24;
	localparam int RANK_WIDTH  = 3;
	localparam int CNT_W       = $clog2(KEEP_COUNT + 1);
	localparam int IDX_W       = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

endpackage

@@ rtl/core/top_k_points_by_height_core.sv @@
// ============================================================================
// Top-K points by height core
// Keeps the highest points of a frame in a sorted register list and streams
// them out, highest first, once the frame has ended.
// ============================================================================
// Order: input register, then kept list; at a frame end, drain buffer, then
// output register. Throughput: one point per cycle unless the input stalls;
// a frame drains at one result per cycle while out_stall is low, and a second
// frame end waits while the previous frame is still draining.
// Reset: the list and all valid flags are cleared; stored coordinates are not.
module top_k_points_by_height_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [tkpbh_pkg::COORD_WIDTH-1:0] pos_x,
	input  logic signed [tkpbh_pkg::COORD_WIDTH-1:0] pos_y,
	input  logic signed [tkpbh_pkg::COORD_WIDTH-1:0] pos_z,
	input  logic                                frame_end,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [tkpbh_pkg::COORD_WIDTH-1:0] out_x,
	output logic signed [tkpbh_pkg::COORD_WIDTH-1:0] out_y,
	output logic signed [tkpbh_pkg::COORD_WIDTH-1:0] out_z,
	output logic [tkpbh_pkg::RANK_WIDTH-1:0]    rank,
	output logic                                run_end
);
	import tkpbh_pkg::*;

	logic             valid_s1;
	point_t           pt_s1;
	logic             fend_s1;

	point_t           kept_q [KEEP_COUNT];
	logic [CNT_W-1:0] kept_cnt_q;

	point_t           drain_q [KEEP_COUNT];
	logic [CNT_W-1:0] drain_cnt_q;
	logic [IDX_W-1:0] drain_idx_q;
	logic             drain_busy_q;

	logic             out_valid_q;
	point_t           out_pt_q;
	logic [RANK_WIDTH-1:0] rank_q;
	logic             run_end_q;

	logic             adv;
	logic             accept;
	logic             out_load;
	logic             drain_last;
	logic [KEEP_COUNT-1:0] ge;
	point_t           next_list [KEEP_COUNT];
	logic [CNT_W-1:0] next_cnt;

	assign adv      = valid_s1 && (!fend_s1 || !drain_busy_q);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;
	assign out_load = drain_busy_q && (!out_valid_q || !out_stall);
	assign drain_last = ((CNT_W'(drain_idx_q) + CNT_W'(1)) == drain_cnt_q);

	always_comb begin
		for (int i = 0; i < KEEP_COUNT; i++) begin
			ge[i] = (CNT_W'(i) < kept_cnt_q) && (kept_q[i].z >= pt_s1.z);
		end
		next_list[0] = ge[0] ? kept_q[0] : pt_s1;
		for (int i = 1; i < KEEP_COUNT; i++) begin
			if (ge[i]) begin
				next_list[i] = kept_q[i];
			end else if (ge[i-1]) begin
				next_list[i] = pt_s1;
			end else begin
				next_list[i] = kept_q[i-1];
			end
		end
		if (kept_cnt_q == CNT_W'(KEEP_COUNT)) begin
			next_cnt = kept_cnt_q;
		end else begin
			next_cnt = kept_cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			kept_cnt_q   <= '0;
			drain_busy_q <= 1'b0;
			drain_cnt_q  <= '0;
			drain_idx_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				kept_cnt_q <= fend_s1 ? '0 : next_cnt;
			end
			if (adv && fend_s1) begin
				drain_busy_q <= 1'b1;
				drain_cnt_q  <= next_cnt;
				drain_idx_q  <= '0;
			end else if (out_load) begin
				drain_idx_q <= drain_idx_q + IDX_W'(1);
				if (drain_last) begin
					drain_busy_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pt_s1.x <= pos_x;
			pt_s1.y <= pos_y;
			pt_s1.z <= pos_z;
			fend_s1 <= frame_end;
		end
		if (adv && !fend_s1) begin
			for (int i = 0; i < KEEP_COUNT; i++) begin
				kept_q[i] <= next_list[i];
			end
		end
		if (adv && fend_s1) begin
			for (int i = 0; i < KEEP_COUNT; i++) begin
				drain_q[i] <= next_list[i];
			end
		end
		if (out_load) begin
			out_pt_q  <= drain_q[drain_idx_q];
			rank_q    <= RANK_WIDTH'(drain_idx_q);
			run_end_q <= drain_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_pt_q.x;
	assign out_y     = out_pt_q.y;
	assign out_z     = out_pt_q.z;
	assign rank      = rank_q;
	assign run_end   = run_end_q;

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_cnt_q <= CNT_W'(KEEP_COUNT))
		else $error("kept list count beyond capacity");

	a_drain_idx: assert property (@(posedge clk) disable iff (!arst_n)
		drain_busy_q |-> (CNT_W'(drain_idx_q) < drain_cnt_q))
		else $error("drain index past the stored frame");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && fend_s1 && drain_busy_q))
		else $error("input stalled without a pending frame end");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && fend_s1) |=> (kept_cnt_q == '0) && drain_busy_q)
		else $error("frame end did not hand over and clear the list");

endmodule
